// ===== rtl/core/atcl_pkg.sv =====
// Package for the adaptive thread-count learner.
// Holds field widths, register indexes, default parameter values and shared types.
// No dependencies; every other file of the block uses it.
package atcl_pkg;

    // Default sizing of the learner
    localparam int DEF_PROFILE_SLOTS = 16;
    localparam int DEF_THREAD_LIMIT  = 8;
    localparam int DEF_BUCKET_BYTES  = 1024;

    // Fixed field widths
    localparam int CMD_W  = 1;
    localparam int CLS_W  = 3;
    localparam int SIZE_W = 31;
    localparam int FREE_W = 16;
    localparam int CNT_W  = 4;
    localparam int TIME_W = 32;

    // Command codes
    localparam logic CMD_DECIDE = 1'b0;
    localparam logic CMD_UPDATE = 1'b1;

    // Highest known workload class; codes above it fold to unknown
    localparam logic [CLS_W-1:0] CLS_UNKNOWN = 3'd0;
    localparam logic [CLS_W-1:0] CLS_MAX     = 3'd4;

    // Exploration cadence on the profile's total run count
    localparam int EXPLORE_PERIOD    = 4;
    localparam int EXPLORE_UP_PERIOD = 8;

    // Configuration port
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = 2;
    localparam logic [REG_IDX_W-1:0] REG_NAIVE_MODE    = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_DEFAULT_SPLIT = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_OVERHEAD      = 2'd2;

    localparam logic [CNT_W-1:0] SPLIT_RESET = 4'd2;

    // Shared divider widths: 64-bit dividend, 33-bit divisor
    localparam int DVD_W = 64;
    localparam int DVS_W = 33;

    // Configuration register values
    typedef struct packed {
        logic              naive_mode;
        logic [CNT_W-1:0]  split_val;
        logic [TIME_W-1:0] overhead_per_thread;
    } cfg_t;

    // Divider request and response
    typedef struct packed {
        logic             start;
        logic [DVD_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DVD_W-1:0] quotient;
    } div_rsp_t;

    // Smaller of the free thread count and a thread count
    function automatic logic [CNT_W-1:0] min_free(input logic [FREE_W-1:0] free_t,
                                                  input logic [CNT_W-1:0]  cnt);
        logic [CNT_W-1:0] r;
        if (free_t < FREE_W'(cnt))
            r = free_t[CNT_W-1:0];
        else
            r = cnt;
        return r;
    endfunction

endpackage

// ===== rtl/core/atcl_if.sv =====
// Handshake interfaces for the request and result channels of the learner.
// Depends on atcl_pkg for field widths.
interface atcl_req_if;
    logic                        valid;
    logic                        ready;
    logic [atcl_pkg::CMD_W-1:0]  cmd;
    logic [atcl_pkg::CLS_W-1:0]  job_class;
    logic [atcl_pkg::SIZE_W-1:0] job_size;
    logic [atcl_pkg::FREE_W-1:0] avail_threads;
    logic [atcl_pkg::CNT_W-1:0]  threads_used;
    logic [atcl_pkg::TIME_W-1:0] elapsed_time;

    modport source (output valid, cmd, job_class, job_size, avail_threads,
                    threads_used, elapsed_time, input ready);
    modport sink (input valid, cmd, job_class, job_size, avail_threads,
                  threads_used, elapsed_time, output ready);
endinterface

interface atcl_rsp_if;
    logic                       valid;
    logic                       ready;
    logic [atcl_pkg::CNT_W-1:0] granted_threads;
    logic [atcl_pkg::CNT_W-1:0] best_threads;
    logic                       explored;
    logic                       profile_found;
    logic                       table_full;

    modport source (output valid, granted_threads, best_threads, explored,
                    profile_found, table_full, input ready);
    modport sink (input valid, granted_threads, best_threads, explored,
                  profile_found, table_full, output ready);
endinterface

// ===== rtl/core/atcl_div.sv =====
// Restoring divider of the learner, one quotient bit per cycle.
// Depends on atcl_pkg for widths and the request and response types.
module atcl_div (
    input  logic               clk,
    input  logic               rst_n,
    input  atcl_pkg::div_req_t req,
    output atcl_pkg::div_rsp_t rsp
);

    localparam int CW = $clog2(atcl_pkg::DVD_W + 1);

    logic                       busy_reg;
    logic                       done_reg;
    logic [CW-1:0]              cnt_reg;
    logic [atcl_pkg::DVD_W-1:0] quo_reg;
    logic [atcl_pkg::DVS_W-1:0] rem_reg;
    logic [atcl_pkg::DVS_W-1:0] dvs_reg;

    logic [atcl_pkg::DVS_W:0]   rem_sh;
    logic [atcl_pkg::DVS_W:0]   dvs_ext;
    logic                       ge;
    logic [atcl_pkg::DVS_W:0]   rem_next;

    // One trial subtraction per cycle
    always_comb
    begin
        rem_sh   = {rem_reg, quo_reg[atcl_pkg::DVD_W-1]};
        dvs_ext  = {1'b0, dvs_reg};
        ge       = (rem_sh >= dvs_ext);
        rem_next = ge ? (rem_sh - dvs_ext) : rem_sh;
    end

    // Control and datapath registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(atcl_pkg::DVD_W);
                quo_reg  <= req.dividend;
                rem_reg  <= '0;
                dvs_reg  <= req.divisor;
            end
            else if (busy_reg)
            begin
                rem_reg <= rem_next[atcl_pkg::DVS_W-1:0];
                quo_reg <= {quo_reg[atcl_pkg::DVD_W-2:0], ge};
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

// ===== rtl/core/atcl_cfg.sv =====
// Configuration register file of the learner on an APB-style port.
// Depends on atcl_pkg for register indexes, widths and the cfg_t type.
module atcl_cfg (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [atcl_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [atcl_pkg::APB_DATA_W-1:0] pwdata,
    output logic [atcl_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready,
    output atcl_pkg::cfg_t                  cfg
);

    logic                          naive_reg;
    logic [atcl_pkg::CNT_W-1:0]    split_reg;
    logic [atcl_pkg::TIME_W-1:0]   overhead_reg;
    logic [atcl_pkg::REG_IDX_W-1:0] idx;
    logic                          wr;

    assign idx    = paddr[atcl_pkg::APB_ADDR_W-1:2];
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;

    // Register writes in the access phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            naive_reg    <= 1'b0;
            split_reg    <= atcl_pkg::SPLIT_RESET;
            overhead_reg <= '0;
        end
        else if (wr)
        begin
            case (idx)
                atcl_pkg::REG_NAIVE_MODE:    naive_reg    <= pwdata[0];
                atcl_pkg::REG_DEFAULT_SPLIT: split_reg    <= pwdata[atcl_pkg::CNT_W-1:0];
                atcl_pkg::REG_OVERHEAD:      overhead_reg <= pwdata;
                default:                     ;
            endcase
        end
    end

    // Read-back
    always_comb
    begin
        case (idx)
            atcl_pkg::REG_NAIVE_MODE:    prdata = {31'b0, naive_reg};
            atcl_pkg::REG_DEFAULT_SPLIT: prdata = {28'b0, split_reg};
            atcl_pkg::REG_OVERHEAD:      prdata = overhead_reg;
            default:                     prdata = '0;
        endcase
    end

    assign cfg.naive_mode          = naive_reg;
    assign cfg.split_val           = split_reg;
    assign cfg.overhead_per_thread = overhead_reg;

endmodule

// ===== rtl/core/adaptive_thread_count_learner.sv =====
// Top level of the adaptive thread-count learner: sequencer, profile store,
// time memory and result register. Depends on atcl_pkg, atcl_if, atcl_div, atcl_cfg.
//
//  channel | kind          | handshake      | content
//  req     | request in    | valid/ready    | cmd, class, size, free, used, time
//  rsp     | result out    | valid/ready    | grant, optimum, explored, found, full
//  apb     | config access | psel/penable   | naive mode, default split, overhead
//
// A decide passes the bucket step, the search over the stored profiles and the decision.
// An update reads the entry for the used thread count, forms the new mean in the divider
// and rescans every thread count; creating a profile first clears its row.
// Reset clears control state only; no clearing pass follows it. A stalled result
// waits in the output register while the next request is already taken.
module adaptive_thread_count_learner #(
    parameter int PROFILE_SLOTS = atcl_pkg::DEF_PROFILE_SLOTS,
    parameter int THREAD_LIMIT  = atcl_pkg::DEF_THREAD_LIMIT,
    parameter int BUCKET_BYTES  = atcl_pkg::DEF_BUCKET_BYTES
) (
    input  logic                            clk,
    input  logic                            rst_n,
    atcl_req_if.sink                        req,
    atcl_rsp_if.source                      rsp,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [atcl_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [atcl_pkg::APB_DATA_W-1:0] pwdata,
    output logic [atcl_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready
);

    localparam int SW    = (PROFILE_SLOTS > 1) ? $clog2(PROFILE_SLOTS) : 1;
    localparam int UW    = $clog2(PROFILE_SLOTS + 1);
    localparam int TW    = $clog2(THREAD_LIMIT + 1);
    localparam int MEM_D = PROFILE_SLOTS << TW;
    localparam int PEN_W = atcl_pkg::TIME_W + TW;
    localparam int SC_W  = PEN_W + 1;
    localparam int TM    = atcl_pkg::TIME_W;
    localparam int CW    = atcl_pkg::CNT_W;

    localparam logic [CW-1:0] LIMIT_C = CW'(THREAD_LIMIT);

    // Exploration periods are powers of two, so the remainder is a mask
    localparam logic [TM-1:0] EXPL_MASK    = TM'(atcl_pkg::EXPLORE_PERIOD - 1);
    localparam logic [TM-1:0] EXPL_UP_MASK = TM'(atcl_pkg::EXPLORE_UP_PERIOD - 1);

    // Bucket by reciprocal multiplication, exact for every 31-bit size
    localparam int BKT_SH = $clog2(BUCKET_BYTES);
    localparam int BKT_K  = atcl_pkg::SIZE_W + BKT_SH;
    localparam int BP_W   = atcl_pkg::SIZE_W + 32;
    localparam logic [63:0] BKT_RECIP =
        ((64'd1 << BKT_K) + 64'(BUCKET_BYTES) - 64'd1) / 64'(BUCKET_BYTES);

    typedef enum logic [3:0] {
        ST_IDLE, ST_BKT_GO, ST_SEARCH, ST_DECIDE, ST_UPD_SEL,
        ST_CLEAR, ST_RD, ST_MUL, ST_DIV_GO, ST_DIV_WAIT, ST_SCAN_RD,
        ST_SCAN_CMP, ST_UPD_END, ST_OUT
    } state_t;

    atcl_pkg::cfg_t     cfg;
    atcl_pkg::div_req_t div_req;
    atcl_pkg::div_rsp_t div_rsp;

    state_t                      state_reg;
    logic                        cmd_reg;
    logic [atcl_pkg::CLS_W-1:0]  cls_reg;
    logic [atcl_pkg::SIZE_W-1:0] size_reg;
    logic [atcl_pkg::FREE_W-1:0] free_reg;
    logic [CW-1:0]               used_reg;
    logic [TM-1:0]               elapsed_reg;
    logic [atcl_pkg::SIZE_W-1:0] bucket_reg;
    logic [UW-1:0]               idx_reg;
    logic [SW-1:0]               slot_reg;
    logic                        found_reg;
    logic [UW-1:0]               nprof_reg;
    logic [TW-1:0]               t_reg;
    logic [TM-1:0]               n_reg;
    logic [2*TM-1:0]             prod_reg;
    logic [PEN_W-1:0]            pen_reg;
    logic [SC_W-1:0]             low_score_reg;
    logic                        have_reg;
    logic [CW-1:0]               best_reg;

    // Pending result
    logic [CW-1:0] res_grant_reg;
    logic [CW-1:0] res_opt_reg;
    logic          res_expl_reg;
    logic          res_full_reg;

    // Output register
    logic          out_valid_reg;
    logic [CW-1:0] out_grant_reg;
    logic [CW-1:0] out_opt_reg;
    logic          out_expl_reg;
    logic          out_found_reg;
    logic          out_full_reg;

    // Profile keys and per-profile values
    logic [atcl_pkg::CLS_W-1:0]  ent_class  [PROFILE_SLOTS];
    logic [atcl_pkg::SIZE_W-1:0] ent_bucket [PROFILE_SLOTS];
    logic [CW-1:0]               ent_best   [PROFILE_SLOTS];
    logic [TM-1:0]               ent_total  [PROFILE_SLOTS];

    // Run count and mean time per profile and thread count
    logic [2*TM-1:0]   mem [MEM_D];
    logic [2*TM-1:0]   mem_q;
    logic              mem_we;
    logic              mem_re;
    logic [SW+TW-1:0]  mem_addr;
    logic [2*TM-1:0]   mem_wdata;

    logic [CW-1:0]     split_c;
    logic [CW-1:0]     cur_best;
    logic [TM-1:0]     cur_total;
    logic [CW-1:0]     dec_grant;
    logic              dec_expl;
    logic [CW:0]       ex_val;
    logic [CW-1:0]     ex_clamp;
    logic [TM-1:0]     new_run;
    logic [SC_W-1:0]   score;
    logic              used_ok;
    logic [atcl_pkg::CLS_W-1:0] cls_in;
    logic [BP_W-1:0]   bkt_prod;
    logic [BP_W-1:0]   bkt_quo;

    atcl_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    atcl_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign cur_best  = ent_best[slot_reg];
    assign cur_total = ent_total[slot_reg];
    assign used_ok   = ({28'b0, used_reg} <= 32'(THREAD_LIMIT));
    assign cls_in    = (req.job_class > atcl_pkg::CLS_MAX) ?
                       atcl_pkg::CLS_UNKNOWN : req.job_class;

    // Size bucket: multiply by the scaled reciprocal, keep the high part
    assign bkt_prod = BP_W'(size_reg) * BP_W'(BKT_RECIP[31:0]);
    assign bkt_quo  = bkt_prod >> BKT_K;

    // Default split clamped to the legal thread range
    always_comb
    begin
        if (cfg.split_val == '0)
            split_c = CW'(1);
        else if (cfg.split_val > LIMIT_C)
            split_c = LIMIT_C;
        else
            split_c = cfg.split_val;
    end

    // Decide grant: default split in naive mode or without a profile, else the optimum with exploration around it
    always_comb
    begin
        if ((cur_total & EXPL_UP_MASK) == '0)
            ex_val = {1'b0, cur_best} + 1'b1;
        else
            ex_val = {1'b0, cur_best} - 1'b1;
        if (ex_val == '0)
            ex_clamp = CW'(1);
        else if (ex_val > {1'b0, LIMIT_C})
            ex_clamp = LIMIT_C;
        else
            ex_clamp = ex_val[CW-1:0];

        dec_expl = 1'b0;
        if (cfg.naive_mode || !found_reg)
            dec_grant = atcl_pkg::min_free(free_reg, split_c);
        else if (cur_total != '0 && (cur_total & EXPL_MASK) == '0)
        begin
            dec_grant = atcl_pkg::min_free(free_reg, ex_clamp);
            dec_expl  = 1'b1;
        end
        else
            dec_grant = atcl_pkg::min_free(free_reg, cur_best);
        if (dec_grant == '0)
            dec_grant = CW'(1);
    end

    assign new_run = (n_reg == '1) ? n_reg : n_reg + 1'b1;
    assign score   = SC_W'(mem_q[TM-1:0]) + SC_W'(pen_reg);

    // Memory and divider control from the sequencer state
    always_comb
    begin
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_addr  = {slot_reg, t_reg};
        mem_wdata = '0;
        div_req.start    = 1'b0;
        div_req.dividend = '0;
        div_req.divisor  = '0;
        case (state_reg)
            ST_CLEAR:
            begin
                mem_we = 1'b1;
            end
            ST_RD:
            begin
                mem_re   = 1'b1;
                mem_addr = {slot_reg, TW'(used_reg)};
            end
            ST_DIV_GO:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = prod_reg + {32'b0, elapsed_reg};
                div_req.divisor  = {1'b0, n_reg} + 1'b1;
            end
            ST_DIV_WAIT:
            begin
                mem_we    = div_rsp.done;
                mem_addr  = {slot_reg, TW'(used_reg)};
                mem_wdata = {new_run, div_rsp.quotient[TM-1:0]};
            end
            ST_SCAN_RD:
            begin
                mem_re = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    // Time memory, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_addr] <= mem_wdata;
        if (mem_re)
            mem_q <= mem[mem_addr];
    end

    // Sequencer, profile store and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            nprof_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // The output state reloads the register itself when it is taken
            if (out_valid_reg && rsp.ready && state_reg != ST_OUT)
                out_valid_reg <= 1'b0;

            case (state_reg)
                ST_IDLE:
                begin
                    if (req.valid)
                    begin
                        cmd_reg     <= req.cmd;
                        cls_reg     <= cls_in;
                        size_reg    <= req.job_size;
                        free_reg    <= req.avail_threads;
                        used_reg    <= req.threads_used;
                        elapsed_reg <= req.elapsed_time;
                        state_reg   <= ST_BKT_GO;
                    end
                end
                ST_BKT_GO:
                begin
                    bucket_reg <= bkt_quo[atcl_pkg::SIZE_W-1:0];
                    idx_reg    <= '0;
                    found_reg  <= 1'b0;
                    state_reg  <= ST_SEARCH;
                end
                // Linear search over the stored profiles
                ST_SEARCH:
                begin
                    if (idx_reg == nprof_reg)
                        state_reg <= (cmd_reg == atcl_pkg::CMD_DECIDE) ? ST_DECIDE
                                                                       : ST_UPD_SEL;
                    else if (ent_class[idx_reg[SW-1:0]] == cls_reg &&
                             ent_bucket[idx_reg[SW-1:0]] == bucket_reg)
                    begin
                        found_reg <= 1'b1;
                        slot_reg  <= idx_reg[SW-1:0];
                        state_reg <= (cmd_reg == atcl_pkg::CMD_DECIDE) ? ST_DECIDE
                                                                       : ST_UPD_SEL;
                    end
                    else
                        idx_reg <= idx_reg + 1'b1;
                end
                ST_DECIDE:
                begin
                    res_grant_reg <= dec_grant;
                    res_opt_reg   <= found_reg ? cur_best : '0;
                    res_expl_reg  <= dec_expl;
                    res_full_reg  <= 1'b0;
                    state_reg     <= ST_OUT;
                end
                // Pick or create the profile for an update, or finish on a bad thread count or a full table
                ST_UPD_SEL:
                begin
                    res_grant_reg <= '0;
                    res_expl_reg  <= 1'b0;
                    res_full_reg  <= 1'b0;
                    if (!used_ok)
                    begin
                        res_opt_reg <= found_reg ? cur_best : '0;
                        state_reg   <= ST_OUT;
                    end
                    else if (found_reg)
                        state_reg <= ST_RD;
                    else if (nprof_reg < UW'(PROFILE_SLOTS))
                    begin
                        slot_reg                       <= nprof_reg[SW-1:0];
                        ent_class[nprof_reg[SW-1:0]]   <= cls_reg;
                        ent_bucket[nprof_reg[SW-1:0]]  <= bucket_reg;
                        ent_best[nprof_reg[SW-1:0]]    <= split_c;
                        ent_total[nprof_reg[SW-1:0]]   <= '0;
                        nprof_reg                      <= nprof_reg + 1'b1;
                        t_reg                          <= '0;
                        state_reg                      <= ST_CLEAR;
                    end
                    else
                    begin
                        res_opt_reg  <= '0;
                        res_full_reg <= 1'b1;
                        state_reg    <= ST_OUT;
                    end
                end
                // Zero the new profile's row, one thread count per cycle
                ST_CLEAR:
                begin
                    if (t_reg == TW'(THREAD_LIMIT))
                        state_reg <= ST_RD;
                    else
                        t_reg <= t_reg + 1'b1;
                end
                ST_RD:
                begin
                    state_reg <= ST_MUL;
                end
                ST_MUL:
                begin
                    n_reg     <= mem_q[2*TM-1:TM];
                    prod_reg  <= mem_q[TM-1:0] * mem_q[2*TM-1:TM];
                    state_reg <= ST_DIV_GO;
                end
                ST_DIV_GO:
                begin
                    state_reg <= ST_DIV_WAIT;
                end
                ST_DIV_WAIT:
                begin
                    if (div_rsp.done)
                    begin
                        ent_total[slot_reg] <= cur_total + 1'b1;
                        t_reg               <= TW'(1);
                        pen_reg             <= PEN_W'(cfg.overhead_per_thread);
                        have_reg            <= 1'b0;
                        best_reg            <= cur_best;
                        state_reg           <= ST_SCAN_RD;
                    end
                end
                // Rescan for the thread count with the lowest score
                ST_SCAN_RD:
                begin
                    state_reg <= ST_SCAN_CMP;
                end
                ST_SCAN_CMP:
                begin
                    if (mem_q[2*TM-1:TM] != '0 && (!have_reg || score < low_score_reg))
                    begin
                        have_reg      <= 1'b1;
                        low_score_reg <= score;
                        best_reg      <= CW'(t_reg);
                    end
                    pen_reg <= pen_reg + PEN_W'(cfg.overhead_per_thread);
                    if (t_reg == TW'(THREAD_LIMIT))
                        state_reg <= ST_UPD_END;
                    else
                    begin
                        t_reg     <= t_reg + 1'b1;
                        state_reg <= ST_SCAN_RD;
                    end
                end
                ST_UPD_END:
                begin
                    ent_best[slot_reg] <= best_reg;
                    res_opt_reg        <= best_reg;
                    found_reg          <= found_reg;
                    state_reg          <= ST_OUT;
                end
                // Hand the result to the output register once it is free
                ST_OUT:
                begin
                    if (!out_valid_reg || rsp.ready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_grant_reg <= res_grant_reg;
                        out_opt_reg   <= res_opt_reg;
                        out_expl_reg  <= res_expl_reg;
                        out_found_reg <= found_reg;
                        out_full_reg  <= res_full_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign req.ready           = (state_reg == ST_IDLE);
    assign rsp.valid           = out_valid_reg;
    assign rsp.granted_threads = out_grant_reg;
    assign rsp.best_threads    = out_opt_reg;
    assign rsp.explored        = out_expl_reg;
    assign rsp.profile_found   = out_found_reg;
    assign rsp.table_full      = out_full_reg;

endmodule
